[hdl/u8s8_dot_product_tile_accumulator_defines.svh]
// Assertion macros shared by the dot product tile accumulator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef U8S8_DOT_PRODUCT_TILE_ACCUMULATOR_DEFINES_SVH
`define U8S8_DOT_PRODUCT_TILE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8S8DP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8S8DP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/u8s8dp_pkg.sv]
// Package for the dot product tile accumulator: sizes, command codes,
// register indexes and the lane control struct. No dependencies.
package u8s8dp_pkg;

  localparam int LANES     = 8;
  localparam int LANE_W    = 3;
  localparam int ACC_W     = 32;
  localparam int QUAD_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 424;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  // Bit offsets of the input fields in in_tdata.
  localparam int LANE_LSB  = 0;
  localparam int ROW_LSB   = 3;
  localparam int COL_LSB   = 35;
  localparam int ZP_LSB    = 67;
  localparam int PRIOR_LSB = 99;
  localparam int AQ_LSB    = 131;
  localparam int B_LSB     = 163;
  localparam int B_W       = LANES * QUAD_W;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_CZP   = 1'd1;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_QUAD = 2'd1,
    CMD_EMIT = 2'd2
  } cmd_t;

  typedef struct packed {
    logic cap;
    logic add;
    logic load;
  } lane_ctl_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [ACC_W-1:0]  c_value;
  } result_t;

endpackage

[hdl/u8s8dp_lane.sv]
// One column lane: four byte products registered, then pair sums
// saturated to 16 bits and added to the lane accumulator. Uses u8s8dp_pkg.
module u8s8dp_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  u8s8dp_pkg::lane_ctl_t        ctl,
  input  logic [u8s8dp_pkg::QUAD_W-1:0] a_quad,
  input  logic [u8s8dp_pkg::QUAD_W-1:0] b_quad,
  input  logic [u8s8dp_pkg::ACC_W-1:0]  init_value,
  output logic [u8s8dp_pkg::ACC_W-1:0]  acc
);
  import u8s8dp_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return -16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  logic signed [16:0] prod_nxt [4];
  logic signed [16:0] prod_r   [4];
  logic signed [17:0] pair0, pair1;
  logic signed [16:0] quad_sum;
  logic [ACC_W-1:0]   acc_r, acc_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      prod_nxt[j] = 17'($signed({1'b0, a_quad[8*j +: 8]})) * 17'($signed(b_quad[8*j +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      for (int j = 0; j < 4; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
    end
  end

  assign pair0    = 18'(prod_r[0]) + 18'(prod_r[1]);
  assign pair1    = 18'(prod_r[2]) + 18'(prod_r[3]);
  assign quad_sum = 17'(sat16(pair0)) + 17'(sat16(pair1));

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = init_value;
    end else if (ctl.add) begin
      acc_nxt = acc_r + 32'(quad_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[hdl/u8s8dp_merge_q.sv]
// Emit merge and result queue: adds prior_c to the selected lane value unless
// zero_mode is set, and holds up to two results for output. Uses u8s8dp_pkg.
`include "u8s8_dot_product_tile_accumulator_defines.svh"

module u8s8dp_merge_q (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic [u8s8dp_pkg::ACC_W-1:0]       acc_sel,
  input  logic [u8s8dp_pkg::ACC_W-1:0]       prior_c,
  input  logic [u8s8dp_pkg::LANE_W-1:0]      lane,
  input  logic                              zero_mode,
  output logic                              full,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [u8s8dp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import u8s8dp_pkg::*;

  result_t     mem_r [2];
  result_t     res;
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign res.lane    = lane;
  assign res.c_value = zero_mode ? acc_sel : acc_sel + prior_c;

  assign out_tvalid = (cnt_r != 2'd0);
  assign full       = (cnt_r == 2'd2);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, mem_r[rd_ptr_r]};

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

  `U8S8DP_ASSERT_IMP(a_no_push_full, push, cnt_r != 2'd2, "result pushed into a full queue")
  `U8S8DP_ASSERT_NXT(a_pop_drains, pop && !push, cnt_r == $past(cnt_r) - 2'd1,
                     "queue count did not drop after a transfer")

endmodule

[hdl/u8s8_dot_product_tile_accumulator.sv]
// Top level of the u8 by s8 dot product tile accumulator.
// Uses u8s8dp_pkg, u8s8dp_lane and u8s8dp_merge_q.
//
// Usage: items arrive on the in_ stream, cmd in in_tuser, the other fields
// packed in in_tdata. Init loads one lane accumulator, quad adds the two
// saturated pair sums of every lane, emit sends one lane on the out_ stream.
// Registers zero_mode and use_column_zero_point are written on the cfg_
// port; the user writes them only while the block is idle (not enforced).
// Throughput: one item per cycle sustained unless an emit waits on a full
// result queue. Each item is registered in the operand stage (byte products
// per lane, the shared 32 by 32 multiplier for init) and acts on the
// accumulators in the next cycle. Emit path: an emit is pushed from the
// operand stage into the result queue, whose count drives out_tvalid.
// Reset clears every accumulator, sets zero_mode to 1 and clears
// use_column_zero_point; the operand stage and the result queue start empty.
// Stalls: a two-entry result queue absorbs a stalled receiver; when it is
// full and an emit waits in the operand stage, in_tready drops until a
// result transfer frees an entry.
`include "u8s8_dot_product_tile_accumulator_defines.svh"

module u8s8_dot_product_tile_accumulator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // lane, row_sum, column_sum, zero_point_b, prior_c, a_quad,
  // b_lanes_0_1, b_lanes_2_3, b_lanes_4_5, b_lanes_6_7, zero padding
  input  logic [u8s8dp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd
  input  logic [u8s8dp_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // c_value, out_lane, zero padding
  output logic [u8s8dp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [u8s8dp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic                                  cfg_wdata
);
  import u8s8dp_pkg::*;

  logic              zero_mode_r, zero_mode_nxt;
  logic              use_czp_r, use_czp_nxt;

  logic              s1_v_r, s1_v_nxt;
  cmd_t              s1_cmd_r;
  logic [LANE_W-1:0] s1_lane_r;
  logic [ACC_W-1:0]  s1_base_r, s1_col_r, s1_prior_r;

  logic              accept, fire, q_full;
  logic [ACC_W-1:0]  row_sum, zp, base_nxt, init_value;
  logic [ACC_W-1:0]  lane_acc [LANES];
  lane_ctl_t         lane_ctl [LANES];

  always_comb begin
    zero_mode_nxt = zero_mode_r;
    use_czp_nxt   = use_czp_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ZERO_MODE: zero_mode_nxt = cfg_wdata;
        REG_USE_CZP:   use_czp_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fire      = s1_v_r && !(s1_cmd_r == CMD_EMIT && q_full);
  assign in_tready = !s1_v_r || fire;
  assign accept    = in_tvalid && in_tready;

  assign row_sum  = in_tdata[ROW_LSB +: ACC_W];
  assign zp       = in_tdata[ZP_LSB +: ACC_W];
  assign base_nxt = use_czp_r ? 32'(row_sum * zp) : row_sum;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_mode_r <= 1'b1;
      use_czp_r   <= 1'b0;
      s1_v_r      <= 1'b0;
    end else begin
      zero_mode_r <= zero_mode_nxt;
      use_czp_r   <= use_czp_nxt;
      s1_v_r      <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r   <= cmd_t'(in_tuser[1:0]);
      s1_lane_r  <= in_tdata[LANE_LSB +: LANE_W];
      s1_base_r  <= base_nxt;
      s1_col_r   <= in_tdata[COL_LSB +: ACC_W];
      s1_prior_r <= in_tdata[PRIOR_LSB +: ACC_W];
    end
  end

  assign init_value = s1_base_r + s1_col_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_ctl[i].cap  = accept;
    assign lane_ctl[i].add  = fire && (s1_cmd_r == CMD_QUAD);
    assign lane_ctl[i].load = fire && (s1_cmd_r == CMD_INIT)
                              && (s1_lane_r == LANE_W'(i));

    u8s8dp_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (lane_ctl[i]),
      .a_quad     (in_tdata[AQ_LSB +: QUAD_W]),
      .b_quad     (in_tdata[B_LSB + QUAD_W*i +: QUAD_W]),
      .init_value (init_value),
      .acc        (lane_acc[i])
    );
  end

  u8s8dp_merge_q u_merge_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire && (s1_cmd_r == CMD_EMIT)),
    .acc_sel    (lane_acc[s1_lane_r]),
    .prior_c    (s1_prior_r),
    .lane       (s1_lane_r),
    .zero_mode  (zero_mode_r),
    .full       (q_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `U8S8DP_ASSERT_IMP(a_stall_cause, !in_tready,
                     s1_v_r && s1_cmd_r == CMD_EMIT && q_full,
                     "input stalled without a blocked emit")

endmodule
